@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files that carry checks
// no dependencies; compiled ahead of any file that includes it
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/mt_pkg.sv @@
// shared types, constants and tempering function for the mt19937 generator
// no dependencies; compiled first
package mt_pkg;

  localparam int TABLE_DEPTH  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int FAR_WRAP     = TABLE_DEPTH - TWIST_OFFSET;
  localparam int WORD_W       = 32;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);

  localparam logic [WORD_W-1:0] SEED_MULT  = 32'h6c07_8965;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7fff_ffff;

  // action codes carried on tuser
  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_NEXT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_RD_NXT,
    ST_RD_FAR,
    ST_TWIST
  } mt_state_t;

  // which table entry the read port addresses
  typedef enum logic [1:0] {
    RD_CUR,
    RD_NXT,
    RD_FAR
  } mt_rd_sel_t;

  typedef struct packed {
    logic       seed_load;
    logic       seed_write;
    logic       rd_en;
    mt_rd_sel_t rd_sel;
    logic       cur_latch;
    logic       nxt_latch;
    logic       twist_commit;
  } mt_cmd_t;

  typedef struct packed {
    logic seed_last;
    logic out_full;
  } mt_status_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ hw/rtl/mt_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/mt_ctrl.sv @@
// controller state machine for the mt19937 generator
// depends on mt_pkg
module mt_ctrl
  import mt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_action,
  output logic       in_tready,
  output mt_cmd_t    cmd,
  input  mt_status_t status
);

  mt_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.rd_sel = RD_CUR;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        // current entry is fetched speculatively every idle cycle
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CUR;
        if (in_tvalid) begin
          if (in_action == ACT_SEED) begin
            cmd.seed_load = 1'b1;
            state_nxt     = ST_SEED;
          end else begin
            state_nxt = ST_RD_NXT;
          end
        end
      end
      ST_SEED: begin
        cmd.seed_write = 1'b1;
        if (status.seed_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_NXT: begin
        cmd.cur_latch = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_NXT;
        state_nxt     = ST_RD_FAR;
      end
      ST_RD_FAR: begin
        cmd.nxt_latch = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_FAR;
        state_nxt     = ST_TWIST;
      end
      ST_TWIST: begin
        // wait for room in the output register
        if (!status.out_full) begin
          cmd.twist_commit = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/mt_dpath.sv @@
// datapath: seeding recurrence, per-entry twist, tempering and output register
// depends on mt_pkg and mt_ram
module mt_dpath
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] seed_in,
  input  mt_cmd_t           cmd,
  output mt_status_t        status,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata
);

  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [WORD_W-1:0] seed_val_r, seed_val_nxt;
  logic [WORD_W-1:0] cur_r, nxt_r;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;

  logic [ADDR_W-1:0] idx_inc;
  logic [WORD_W-1:0] seed_mix, seed_prod;
  logic [ADDR_W-1:0] addr_nxt, addr_far, raddr, waddr;
  logic [WORD_W-1:0] rdata, wdata, y, twisted;
  logic              we;

  // neighbour and far addresses, wrapping round the table
  assign addr_nxt = (pos_r == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : pos_r + ADDR_W'(1);
  assign addr_far = (pos_r >= ADDR_W'(FAR_WRAP)) ? pos_r - ADDR_W'(FAR_WRAP)
                                                 : pos_r + ADDR_W'(TWIST_OFFSET);

  always_comb begin
    case (cmd.rd_sel)
      RD_CUR:  raddr = pos_r;
      RD_NXT:  raddr = addr_nxt;
      RD_FAR:  raddr = addr_far;
      default: raddr = pos_r;
    endcase
  end

  // seeding recurrence, one entry per cycle
  assign idx_inc   = idx_r + ADDR_W'(1);
  assign seed_mix  = seed_val_r ^ (seed_val_r >> 30);
  assign seed_prod = SEED_MULT * seed_mix;

  // twist of the entry at the read position
  assign y       = (cur_r & UPPER_BIT) | (nxt_r & LOWER_BITS);
  assign twisted = rdata ^ (y >> 1) ^ (y[0] ? TWIST_XOR : '0);

  assign we    = cmd.seed_write | cmd.twist_commit;
  assign waddr = cmd.seed_write ? idx_r : pos_r;
  assign wdata = cmd.seed_write ? seed_val_r : twisted;

  mt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // next values
  always_comb begin
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    seed_val_nxt  = seed_val_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.seed_load) begin
      seed_val_nxt = seed_in;
      idx_nxt      = '0;
      pos_nxt      = '0;
    end else if (cmd.seed_write) begin
      seed_val_nxt = seed_prod + {{(WORD_W - ADDR_W){1'b0}}, idx_inc};
      idx_nxt      = idx_inc;
    end
    if (cmd.twist_commit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = temper(twisted);
      pos_nxt       = addr_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    seed_val_r <= seed_val_nxt;
    out_data_r <= out_data_nxt;
    if (cmd.cur_latch) begin
      cur_r <= rdata;
    end
    if (cmd.nxt_latch) begin
      nxt_r <= rdata;
    end
  end

  assign status.seed_last = (idx_r == ADDR_W'(TABLE_DEPTH - 1));
  assign status.out_full  = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/mt19937_random_generator_top.sv @@
// mt19937 generator top: a next beat reads the current, next and far entries in
// turn through the single table read port, then writes the twisted entry back
// once the output register has room; a seed beat writes one table entry per cycle
// synchronous active-low reset clears the controller, read position and output
// valid; table contents stay undefined until a seed beat writes them
// depends on mt_pkg, mt_ctrl, mt_dpath, mt_ram and assert_macros.svh
`include "assert_macros.svh"
module mt19937_random_generator_top
  import mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] seed_value
  input  logic              in_tuser,   // [0] action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata   // [31:0] random_word
);

  mt_cmd_t    cmd;
  mt_status_t status;

  mt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .status    (status)
  );

  mt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed_in    (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // no table write while waiting for a beat
  `ASSERT_IMPLY(a_idle_no_write, in_tready, !cmd.seed_write && !cmd.twist_commit)
  // a twisted entry always lands in the output register
  `ASSERT_NEXT(a_commit_shows, cmd.twist_commit, out_tvalid)
  // a seed beat keeps the input closed while the table fills
  `ASSERT_NEXT(a_seed_busy, in_tvalid && in_tready && (in_tuser == ACT_SEED), !in_tready)

endmodule

@@ tb/sv/mt19937_random_generator_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for mt19937_random_generator_top: seed and next beats
// go in on the input stream, tempered words are checked against a behavioural twister
// depends on mt_pkg and the generator rtl
module mt19937_random_generator_top_tb;
  import mt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 700;

  typedef struct packed {
    logic        action;
    logic [31:0] seed;
  } mt_beat_t;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TRICKLE
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = ACT_SEED;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  mt_beat_t    pending_beats[$];
  logic [31:0] word_due_q[$];
  int          error_count = 0;
  int          cycle_count = 0;

  // behavioural copy of the generator state
  logic [31:0] model_words[TABLE_DEPTH];
  int unsigned model_pos = 0;

  mt19937_random_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial forever #5 clk = ~clk;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic void add_beat(input logic action, input logic [31:0] seed);
    mt_beat_t b;
    b.action = action;
    b.seed   = seed;
    pending_beats.push_back(b);
  endfunction

  // update the model for one accepted beat and, for a next beat, queue the word it yields
  task automatic apply_beat(input mt_beat_t b);
    logic [31:0] e;
    logic [31:0] y;
    if (b.action == ACT_SEED) begin
      model_words[0] = b.seed;
      for (int i = 1; i < TABLE_DEPTH; i++) begin
        e = model_words[i-1];
        model_words[i] = SEED_MULT * (e ^ (e >> 30)) + 32'(i);
      end
      model_pos = 0;
    end else begin
      // regenerate the whole table before the first word of each pass
      if (model_pos == 0) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          y = (model_words[i] & UPPER_BIT) |
              (model_words[(i + 1) % TABLE_DEPTH] & LOWER_BITS);
          model_words[i] = model_words[(i + TWIST_OFFSET) % TABLE_DEPTH] ^ (y >> 1) ^
                           (y[0] ? TWIST_XOR : 32'h0);
        end
      end
      // tempering
      y = model_words[model_pos];
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      word_due_q.push_back(y);
      model_pos = (model_pos + 1 == TABLE_DEPTH) ? 0 : model_pos + 1;
    end
  endtask

  // driver: bursts of beats with random gaps in between
  int       burst_left = 1;
  int       gap_left   = 0;
  logic     drive_busy;
  logic     drive_valid;
  mt_beat_t drive_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      drive_busy  = in_tvalid;
      drive_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        apply_beat(pending_beats.pop_front());
        drive_busy  = 1'b0;
        drive_valid = 1'b0;
      end
      if (!drive_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_beats.size() != 0) begin
          drive_beat  = pending_beats[0];
          drive_valid = 1'b1;
          in_tdata   <= drive_beat.seed;
          in_tuser   <= drive_beat.action;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_tvalid <= drive_valid;
    end
  end

  // receiver back-pressure, switching between stall patterns
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  logic     rx_ready;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN:   rx_ready = 1'b1;
      RX_COIN:   rx_ready = 1'($urandom_range(0, 1));
      RX_SPARSE: rx_ready = ($urandom_range(0, 7) != 0);
      default:   rx_ready = ($urandom_range(0, 9) == 0);
    endcase
    out_tready <= rx_ready;
  end

  // monitor: compare each output beat with the oldest predicted word
  logic [31:0] want_word;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (word_due_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word %08h", out_tdata));
      end else begin
        want_word = word_due_q.pop_front();
        if (out_tdata !== want_word)
          note_mismatch($sformatf("random_word %08h, predicted %08h", out_tdata, want_word));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mt19937_random_generator_top_tb: errors");
      $finish;
    end
  end

  initial begin
    // directed: extreme and well-known seeds, a reseed mid-table
    add_beat(ACT_SEED, 32'h0000_0000);
    repeat (3) add_beat(ACT_NEXT, 32'hffff_ffff);
    add_beat(ACT_SEED, 32'hffff_ffff);
    repeat (3) add_beat(ACT_NEXT, 32'h0000_0000);
    add_beat(ACT_SEED, 32'd5489);
    repeat (4) add_beat(ACT_NEXT, $urandom);
    add_beat(ACT_SEED, 32'h8000_0000);
    repeat (2) add_beat(ACT_NEXT, 32'h5555_5555);
    add_beat(ACT_SEED, 32'h0000_0001);
    add_beat(ACT_NEXT, 32'haaaa_aaaa);
    add_beat(ACT_SEED, 32'h7fff_ffff);
    repeat (2) add_beat(ACT_NEXT, $urandom);

    // long run that crosses the table wrap and the second twist
    add_beat(ACT_SEED, $urandom);
    repeat (660) add_beat(ACT_NEXT, $urandom);

    // mixed traffic with occasional reseeds
    repeat (290) begin
      if ($urandom_range(0, 24) == 0)
        add_beat(ACT_SEED, $urandom);
      else
        add_beat(ACT_NEXT, $urandom);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_tvalid) @(posedge clk);
    while (word_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (word_due_q.size() != 0)
      note_mismatch($sformatf("%0d predicted words never arrived", word_due_q.size()));

    if (error_count == 0) begin
      $display("mt19937_random_generator_top_tb: clean");
    end else begin
      $display("mt19937_random_generator_top_tb: errors");
    end
    $finish;
  end

endmodule
